>>> design/mss_pkg.sv
// mss_pkg: shared types and constants for the MP3 stream sniffer.
// No dependencies; imported by every module of the block.
package mss_pkg;

  localparam int POS_BITS_DEF    = 20;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CNT_BITS        = 6;

  localparam logic [CNT_BITS-1:0] MIN_REPEATS_RST = 6'd5;

  localparam logic [7:0] BYTE_SYNC = 8'hFF;
  localparam logic [7:0] SYNC_LO_A = 8'hFA;
  localparam logic [7:0] SYNC_LO_B = 8'hFB;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_G      = 8'h67;

  typedef struct packed {
    logic clear;
    logic tag_hit;
    logic sync_hit;
  } cls_t;

endpackage

>>> design/mp3_stream_sniffer.sv
// mp3_stream_sniffer: top level, front classifier -> queue -> spacing back end.
// Depends on mss_pkg, mss_front, mss_queue, mss_back.
//
// Usage: bytes of a buffer arrive on the in_ channel, one beat per byte;
// in_buffer_start marks the first byte of a new buffer and clears all
// detection state. Every input beat yields exactly one result beat on the
// out_ channel carrying sticky found / tag_seen / frames_seen flags.
// cfg_min_repeats sets how many repeats of the held sync spacing are needed; cfg_ready
// is always high, and writes are meant for idle periods only.
// Throughput: one byte per cycle while in_stall is low. The front classifies
// each accepted byte into the queue (two entries by default); the back end
// pops one entry per cycle into the output register unless out_stall holds
// the result there, and out_valid is driven from that register.
// in_stall rises only when the queue is full, which happens while the
// receiver holds out_stall; the held result stays stable until taken.
// Reset (rst_n low, synchronous) clears all detection state, empties the
// queue and the output register, and sets min_repeats to 5.
module mp3_stream_sniffer #(
  parameter int POS_BITS    = mss_pkg::POS_BITS_DEF,
  parameter int QUEUE_DEPTH = mss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte_in,
  input  logic                         in_buffer_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic                         out_tag_seen,
  output logic                         out_frames_seen,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mss_pkg::CNT_BITS-1:0] cfg_min_repeats
);
  import mss_pkg::*;

  localparam int QW = $bits(cls_t) + POS_BITS;

  cls_t                f_cls, q_cls;
  logic [POS_BITS-1:0] f_spos, q_spos;
  logic                in_accept, q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  mss_front #(.POS_BITS(POS_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .byte_in      (in_byte_in),
    .buffer_start (in_buffer_start),
    .cls          (f_cls),
    .spos         (f_spos)
  );

  mss_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_accept),
    .wdata  ({f_cls, f_spos}),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  ({q_cls, q_spos})
  );

  mss_back #(.POS_BITS(POS_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_min         (cfg_min_repeats),
    .q_valid         (q_valid),
    .q_cls           (q_cls),
    .q_spos          (q_spos),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_tag_seen    (out_tag_seen),
    .out_frames_seen (out_frames_seen)
  );

endmodule

>>> design/mss_front.sv
// mss_front: accepts input bytes, tracks recent bytes and position,
// classifies each beat (tag hit, frame sync, sync position). Uses mss_pkg.
module mss_front #(
  parameter int POS_BITS = mss_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic                buffer_start,
  output mss_pkg::cls_t       cls,
  output logic [POS_BITS-1:0] spos
);
  import mss_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [23:0]         recent_r, recent_nxt, recent_eff;
  logic [POS_BITS-1:0] pos_r, pos_nxt, idx_eff;

  always_comb begin
    recent_eff = buffer_start ? 24'd0 : recent_r;
    idx_eff    = buffer_start ? '0 : pos_r;

    cls.clear    = buffer_start;
    cls.tag_hit  = ((recent_eff[23:16] | CASE_BIT) == CH_X) &&
                   ((recent_eff[15:8]  | CASE_BIT) == CH_I) &&
                   ((recent_eff[7:0]   | CASE_BIT) == CH_N) &&
                   ((byte_in           | CASE_BIT) == CH_G);
    cls.sync_hit = (recent_eff[7:0] == BYTE_SYNC) &&
                   ((byte_in == SYNC_LO_A) || (byte_in == SYNC_LO_B));
    spos         = (idx_eff != '0) ? idx_eff - 1'b1 : '0;

    recent_nxt = {recent_eff[15:0], byte_in};
    pos_nxt    = (idx_eff == POS_MAX) ? idx_eff : idx_eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      pos_r    <= '0;
    end else if (accept) begin
      recent_r <= recent_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

>>> design/mss_queue.sv
// mss_queue: small register FIFO between front and back.
// Generic width; depth default from mss_pkg.
module mss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);
  import mss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PTR_LAST) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == PTR_LAST) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("queue count above depth");

endmodule

>>> design/mss_back.sv
// mss_back: sync spacing test, sticky flags, result register and config reg.
// Consumes classified beats from mss_queue. Uses mss_pkg.
module mss_back #(
  parameter int POS_BITS = mss_pkg::POS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mss_pkg::CNT_BITS-1:0] cfg_min,
  input  logic                        q_valid,
  input  mss_pkg::cls_t               q_cls,
  input  logic [POS_BITS-1:0]         q_spos,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic                        out_tag_seen,
  output logic                        out_frames_seen
);
  import mss_pkg::*;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  logic [CNT_BITS-1:0] min_r;
  logic [POS_BITS-1:0] last_r, last_nxt, last_eff;
  logic [POS_BITS-1:0] held_r, held_nxt, held_eff, sync_gap;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic                have_r, have_nxt, have_eff;
  logic                tag_r, tag_nxt, frm_r, frm_nxt;
  logic                out_valid_r, found_r, otag_r, ofrm_r;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    last_eff = q_cls.clear ? '0   : last_r;
    held_eff = q_cls.clear ? '0   : held_r;
    cnt_eff  = q_cls.clear ? '0   : cnt_r;
    have_eff = q_cls.clear ? 1'b0 : have_r;
    tag_nxt  = (q_cls.clear ? 1'b0 : tag_r) | q_cls.tag_hit;
    frm_nxt  = q_cls.clear ? 1'b0 : frm_r;
    sync_gap = q_spos - last_eff;

    last_nxt = last_eff;
    held_nxt = held_eff;
    cnt_nxt  = cnt_eff;
    have_nxt = have_eff;
    if (q_cls.sync_hit) begin
      if (have_eff && (sync_gap != '0)) begin
        if (sync_gap == held_eff) begin
          if (cnt_eff != CNT_MAX) begin
            cnt_nxt = cnt_eff + 1'b1;
          end
        end else if (sync_gap > held_eff) begin
          held_nxt = sync_gap;
          cnt_nxt  = '0;
        end
      end
      last_nxt = q_spos;
      have_nxt = 1'b1;
      if (cnt_nxt >= min_r) begin
        frm_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MIN_REPEATS_RST;
      last_r      <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      have_r      <= 1'b0;
      tag_r       <= 1'b0;
      frm_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_r <= cfg_min;
      end
      if (q_pop) begin
        last_r      <= last_nxt;
        held_r      <= held_nxt;
        cnt_r       <= cnt_nxt;
        have_r      <= have_nxt;
        tag_r       <= tag_nxt;
        frm_r       <= frm_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      found_r <= tag_nxt | frm_nxt;
      otag_r  <= tag_nxt;
      ofrm_r  <= frm_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_tag_seen    = otag_r;
  assign out_frames_seen = ofrm_r;

  a_found_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (found_r == (otag_r | ofrm_r))) else $error("found mismatch");

  a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (otag_r == tag_r) && (ofrm_r == frm_r))
    else $error("result flags differ from sticky state");

  a_held_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_cls.clear) |=> (held_r >= $past(held_r)))
    else $error("held spacing shrank without buffer start");

endmodule
